// File: rtl/ssdw_pkg.sv
// package for the serial seven-segment display writer
// slot codes, bus command bytes, segment lookup and shared types; no dependencies
`timescale 1ns / 1ps

package ssdw_pkg;

  localparam int unsigned NumDigitsDefault = 4;
  localparam int unsigned MaxSlotsPerItem  = 60;

  localparam logic [7:0] CMD_DATA_MODE  = 8'h40;
  localparam logic [7:0] CMD_ADDR_ZERO  = 8'hC0;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h8F;

  // divide by ten: q = (v * RECIP_TEN) >> RECIP_SHIFT, exact for 14-bit v
  localparam logic [15:0] RECIP_TEN   = 16'd52429;
  localparam int unsigned RECIP_SHIFT = 19;

  typedef enum logic [1:0] {
    SLOT_START = 2'd0,
    SLOT_BIT   = 2'd1,
    SLOT_ACK   = 2'd2,
    SLOT_STOP  = 2'd3
  } slot_kind_e;

  typedef enum logic {
    FE_IDLE,
    FE_CONV
  } fe_state_e;

  typedef enum logic {
    BE_IDLE,
    BE_RUN
  } be_state_e;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] seg_pattern(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0: seg = 8'b0011_1111;
      4'd1: seg = 8'b0000_0110;
      4'd2: seg = 8'b0101_1011;
      4'd3: seg = 8'b0100_1111;
      4'd4: seg = 8'b0110_0110;
      4'd5: seg = 8'b0110_1101;
      4'd6: seg = 8'b0111_1101;
      4'd7: seg = 8'b0000_0111;
      4'd8: seg = 8'b0111_1111;
      4'd9: seg = 8'b0110_1111;
      default: seg = 8'b0000_0000;
    endcase
    return seg;
  endfunction

endpackage

// File: rtl/ssdw_front.sv
// front end: accepts values, splits them into decimal digits one per cycle
// and pushes the segment bytes to the run queue; uses ssdw_pkg
`timescale 1ns / 1ps

module ssdw_front #(
  parameter int unsigned NUM_DIGITS = ssdw_pkg::NumDigitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [13:0]             display_value_i,
  input  ssdw_pkg::q_stat_t       q_stat_i,
  output logic                    push_valid_o,
  output logic [8*NUM_DIGITS-1:0] push_data_o,
  output logic                    tail_o
);

  localparam int unsigned PAT_W      = 8 * NUM_DIGITS;
  localparam int unsigned RUN_LENGTH = 33 + 9 * NUM_DIGITS;
  localparam logic        SPLIT      = (RUN_LENGTH > ssdw_pkg::MaxSlotsPerItem);
  localparam int unsigned CNT_W      = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
  localparam logic [CNT_W-1:0] LAST_DIGIT = CNT_W'(NUM_DIGITS - 1);

  ssdw_pkg::fe_state_e state_q, state_d;
  logic [13:0]      val_q, val_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PAT_W-1:0] pat_q, pat_d;
  logic             cont_q, cont_d;

  logic [29:0]      prod;
  logic [10:0]      quot;
  logic [13:0]      quot_x10;
  logic [3:0]       rem;
  logic [PAT_W-1:0] shifted;

  always_comb begin
    prod     = 30'(val_q) * 30'(ssdw_pkg::RECIP_TEN);
    quot     = prod[29:ssdw_pkg::RECIP_SHIFT];
    quot_x10 = {quot, 3'b000} + {2'b00, quot, 1'b0};
    rem      = 4'(val_q - quot_x10);
    shifted  = (pat_q >> 8) | (PAT_W'(ssdw_pkg::seg_pattern(rem)) << (PAT_W - 8));
  end

  always_comb begin
    state_d      = state_q;
    val_d        = val_q;
    cnt_d        = cnt_q;
    pat_d        = pat_q;
    cont_d       = cont_q;
    in_ready_o   = (state_q == ssdw_pkg::FE_IDLE);
    push_valid_o = 1'b0;
    push_data_o  = shifted;
    tail_o       = 1'b0;
    case (state_q)
      ssdw_pkg::FE_IDLE: begin
        if (in_valid_i) begin
          if (cont_q) begin
            // value taken as the tail of the previous run
            cont_d = 1'b0;
            tail_o = 1'b1;
          end else begin
            val_d   = display_value_i;
            cnt_d   = '0;
            cont_d  = SPLIT;
            state_d = ssdw_pkg::FE_CONV;
          end
        end
      end
      ssdw_pkg::FE_CONV: begin
        if (cnt_q == LAST_DIGIT) begin
          push_valid_o = 1'b1;
          if (!q_stat_i.full) begin
            state_d = ssdw_pkg::FE_IDLE;
          end
        end else begin
          pat_d = shifted;
          val_d = 14'(quot);
          cnt_d = cnt_q + 1'b1;
        end
      end
      default: state_d = ssdw_pkg::FE_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssdw_pkg::FE_IDLE;
      cont_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cont_q  <= cont_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
    pat_q <= pat_d;
  end

endmodule

// File: rtl/ssdw_queue.sv
// two-entry queue of digit segment bytes between front and back end
// uses ssdw_pkg for the status struct
`timescale 1ns / 1ps

module ssdw_queue #(
  parameter int unsigned WIDTH = 8 * ssdw_pkg::NumDigitsDefault
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_valid_i,
  input  logic [WIDTH-1:0]  push_data_i,
  input  logic              pop_i,
  output logic [WIDTH-1:0]  pop_data_o,
  output ssdw_pkg::q_stat_t q_stat_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       push;

  assign q_stat_o.full  = (cnt_q == 2'd2);
  assign q_stat_o.empty = (cnt_q == 2'd0);
  assign push           = push_valid_i && !q_stat_o.full;
  assign pop_data_o     = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      case ({push, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/ssdw_back.sv
// back end: slot sequencer that walks the bus run one slot per cycle, while
// the sink is ready and no tail value is awaited, into an output register; uses ssdw_pkg
`timescale 1ns / 1ps

module ssdw_back #(
  parameter int unsigned NUM_DIGITS = ssdw_pkg::NumDigitsDefault
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ssdw_pkg::q_stat_t       q_stat_i,
  input  logic [8*NUM_DIGITS-1:0] pop_data_i,
  output logic                    pop_o,
  input  logic                    tail_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [1:0]              slot_kind_o,
  output logic                    data_bit_o,
  output logic                    last_slot_o
);

  localparam int unsigned PAT_W       = 8 * NUM_DIGITS;
  localparam int unsigned DIGITS_BASE = 21;
  localparam int unsigned MID_STOP    = DIGITS_BASE + 9 * NUM_DIGITS;
  localparam int unsigned RUN_LENGTH  = MID_STOP + 12;
  localparam int unsigned POS_W       = $clog2(RUN_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(RUN_LENGTH - 1);
  localparam logic        SPLIT       = (RUN_LENGTH > ssdw_pkg::MaxSlotsPerItem);
  localparam logic [POS_W-1:0] TAIL_POS = POS_W'(ssdw_pkg::MaxSlotsPerItem);

  ssdw_pkg::be_state_e state_q, state_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [3:0]       bcnt_q, bcnt_d;
  logic [PAT_W-1:0] pat_q, pat_d;
  logic [1:0]       tail_cnt_q, tail_cnt_d;

  logic                 out_valid_q, out_valid_d;
  ssdw_pkg::slot_kind_e kind_q, kind_d;
  logic                 dbit_q, dbit_d;
  logic                 last_q, last_d;

  ssdw_pkg::slot_kind_e kind;
  logic       dbit;
  logic       is_start, is_stop, in_digits;
  logic [7:0] cur_byte;
  logic       advance, at_last;
  logic       tail_wait, tail_take;

  always_comb begin
    is_start  = (pos_q == POS_W'(0)) || (pos_q == POS_W'(11)) ||
                (pos_q == POS_W'(MID_STOP + 1));
    is_stop   = (pos_q == POS_W'(10)) || (pos_q == POS_W'(MID_STOP)) ||
                (pos_q == POS_W'(MID_STOP + 11));
    in_digits = (pos_q >= POS_W'(DIGITS_BASE)) && (pos_q < POS_W'(MID_STOP));
    if (pos_q < POS_W'(10)) begin
      cur_byte = ssdw_pkg::CMD_DATA_MODE;
    end else if (pos_q < POS_W'(DIGITS_BASE)) begin
      cur_byte = ssdw_pkg::CMD_ADDR_ZERO;
    end else if (in_digits) begin
      cur_byte = pat_q[7:0];
    end else begin
      cur_byte = ssdw_pkg::CMD_DISPLAY_ON;
    end
    dbit = 1'b0;
    if (is_start) begin
      kind = ssdw_pkg::SLOT_START;
    end else if (is_stop) begin
      kind = ssdw_pkg::SLOT_STOP;
    end else if (bcnt_q == 4'd8) begin
      kind = ssdw_pkg::SLOT_ACK;
    end else begin
      kind = ssdw_pkg::SLOT_BIT;
      dbit = cur_byte[bcnt_q[2:0]];
    end
  end

  // rest of a long run waits for its tail value
  assign tail_wait = SPLIT && (pos_q == TAIL_POS) && (tail_cnt_q == 2'd0);
  assign advance   = (state_q == ssdw_pkg::BE_RUN) && (!out_valid_q || out_ready_i) &&
                     !tail_wait;
  assign tail_take = advance && SPLIT && (pos_q == TAIL_POS);
  assign at_last   = (pos_q == LAST_POS);

  always_comb begin
    case ({tail_i, tail_take})
      2'b10:   tail_cnt_d = tail_cnt_q + 2'd1;
      2'b01:   tail_cnt_d = tail_cnt_q - 2'd1;
      default: tail_cnt_d = tail_cnt_q;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    bcnt_d      = bcnt_q;
    pat_d       = pat_q;
    pop_o       = 1'b0;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    dbit_d      = dbit_q;
    last_d      = last_q;

    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (advance) begin
      out_valid_d = 1'b1;
      kind_d      = kind;
      dbit_d      = dbit;
      last_d      = at_last;
      pos_d       = pos_q + 1'b1;
      if (is_start || is_stop) begin
        bcnt_d = 4'd0;
      end else if (bcnt_q == 4'd8) begin
        bcnt_d = 4'd0;
        if (in_digits) begin
          pat_d = pat_q >> 8;
        end
      end else begin
        bcnt_d = bcnt_q + 4'd1;
      end
    end

    case (state_q)
      ssdw_pkg::BE_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = ssdw_pkg::BE_RUN;
        end
      end
      ssdw_pkg::BE_RUN: begin
        if (advance && at_last) begin
          if (!q_stat_i.empty) begin
            pop_o = 1'b1;
          end else begin
            state_d = ssdw_pkg::BE_IDLE;
          end
        end
      end
      default: state_d = ssdw_pkg::BE_IDLE;
    endcase

    if (pop_o) begin
      pat_d  = pop_data_i;
      pos_d  = '0;
      bcnt_d = 4'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssdw_pkg::BE_IDLE;
      pos_q       <= '0;
      bcnt_q      <= 4'd0;
      tail_cnt_q  <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      bcnt_q      <= bcnt_d;
      tail_cnt_q  <= tail_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pat_q  <= pat_d;
    kind_q <= kind_d;
    dbit_q <= dbit_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign slot_kind_o = kind_q;
  assign data_bit_o  = dbit_q;
  assign last_slot_o = last_q;

endmodule

// File: rtl/seven_segment_serial_display_writer.sv
// top level of the serial seven-segment display writer
// instantiates ssdw_front, ssdw_queue and ssdw_back; uses ssdw_pkg
`timescale 1ns / 1ps

// Each value starts a complete two-wire display write of 33 + 9*NUM_DIGITS bus
// slots (69 with four digits): start, 0x40, stop; start, 0xC0, the segment bytes
// lowest digit first, stop; start, 0x8F, stop. Bytes go out LSB first, each
// followed by an ack slot with data_bit low. One slot leaves per cycle when the
// sink is ready and no tail value is awaited; the digit split is done in the
// front end and overlaps with a running write. When a run is longer than 60
// slots the value that follows a starting value is taken as the tail of that
// run: it produces no new write, its contents are dropped, and the slots after
// the first 60 are held back until it has been accepted. Values above the
// digit range show only their low NUM_DIGITS decimal digits. A two-entry
// queue lets the front end accept values while a write is still going out.
module seven_segment_serial_display_writer #(
  parameter int unsigned NUM_DIGITS = ssdw_pkg::NumDigitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [13:0] display_value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  slot_kind_o,
  output logic        data_bit_o,
  output logic        last_slot_o
);

  ssdw_pkg::q_stat_t       q_stat;
  logic                    push_valid;
  logic [8*NUM_DIGITS-1:0] push_data;
  logic [8*NUM_DIGITS-1:0] pop_data;
  logic                    pop;
  logic                    tail;

  ssdw_front #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_front (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .display_value_i,
    .q_stat_i     (q_stat),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .tail_o       (tail)
  );

  ssdw_queue #(
    .WIDTH(8 * NUM_DIGITS)
  ) u_queue (
    .clk_i,
    .rst_ni,
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .pop_i        (pop),
    .pop_data_o   (pop_data),
    .q_stat_o     (q_stat)
  );

  ssdw_back #(
    .NUM_DIGITS(NUM_DIGITS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_stat_i    (q_stat),
    .pop_data_i  (pop_data),
    .pop_o       (pop),
    .tail_i      (tail),
    .out_valid_o,
    .out_ready_i,
    .slot_kind_o,
    .data_bit_o,
    .last_slot_o
  );

  // end of run only on a stop slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && last_slot_o |-> slot_kind_o == ssdw_pkg::SLOT_STOP)
    else $error("last slot flagged on a non-stop slot");

  // data line only driven in data bit slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && slot_kind_o != ssdw_pkg::SLOT_BIT |-> !data_bit_o)
    else $error("data bit high outside a data bit slot");

  // never pop an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("queue popped while empty");

  // a start slot follows the last stop of a run when a transfer continues
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && last_slot_o ##1 out_valid_o |->
      slot_kind_o == ssdw_pkg::SLOT_START)
    else $error("new run does not open with a start slot");

endmodule
